// ===== rtl/core/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 256;
    localparam int IDX_W            = 8;
    localparam int POS_W            = 16;
    localparam int SUM_W            = 48;
    localparam int NRM_W            = 16;
    localparam int EDGE_W           = POS_W + 1;
    localparam int CROSS_W          = 2 * EDGE_W + 1;
    localparam logic [NRM_W-1:0] ONE_Q14 = 16'd16384;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TRI   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef logic [2:0][POS_W-1:0] t_pos3;
    typedef logic [2:0][SUM_W-1:0] t_sum3;
    typedef logic [2:0][NRM_W-1:0] t_nrm3;

endpackage

// ===== rtl/core/vna_if.sv =====
// ----------------------------------------------------------------------------
// vna_if
// Request and result channels of the vertex normal accumulator.
// ----------------------------------------------------------------------------
interface vna_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [7:0]        vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]        corner_a;
    logic [7:0]        corner_b;
    logic [7:0]        corner_c;

    modport source (output valid, action, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink   (input valid, action, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        queried_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;

    modport source (output valid, queried_index, normal_x, normal_y, normal_z,
                    input ready);
    modport sink   (input valid, queried_index, normal_x, normal_y, normal_z,
                    output ready);
endinterface

// ===== rtl/core/vna_norm.sv =====
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalizer: range shift, sum of squares, bit-serial square root
// and restoring division, one step per cycle.
// ----------------------------------------------------------------------------
module vna_norm
    import vna_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_sum3 i_sum,
    output logic  o_done,
    output t_nrm3 o_norm
);

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQ    = 7'b0000100,
        N_ROOT  = 7'b0001000,
        N_DINIT = 7'b0010000,
        N_DIV   = 7'b0100000,
        N_END   = 7'b1000000
    } t_nstate;

    t_nstate           r_state;
    logic [2:0][47:0]  r_m;
    logic [2:0]        r_neg;
    logic [3:0]        r_cnt;
    logic [1:0]        r_k;
    logic [61:0]       r_prod;
    logic [63:0]       r_acc;
    logic [63:0]       r_res;
    logic [63:0]       r_bit;
    logic [45:0]       r_rem;
    logic [45:0]       r_den;
    logic [13:0]       r_q;
    t_nrm3             r_norm;
    logic              r_done;

    logic [47:0] w_mx;
    logic [63:0] w_trial;
    logic [14:0] w_qf;
    logic        w_ge;

    always_comb begin
        w_mx = r_m[0];
        if (r_m[1] > w_mx) w_mx = r_m[1];
        if (r_m[2] > w_mx) w_mx = r_m[2];
        w_trial = r_res + r_bit;
        w_ge    = (r_rem >= r_den);
        w_qf    = {r_q, w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == N_END) || (r_state == N_SHIFT && w_mx == 48'd0);
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i]   <= i_sum[i][47] ? (~i_sum[i] + 48'd1) : i_sum[i];
                            r_neg[i] <= i_sum[i][47];
                        end
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (w_mx == 48'd0) begin
                        r_norm  <= {ONE_Q14, 16'd0, 16'd0};
                        r_state <= N_IDLE;
                    end else if (|w_mx[47:31]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (!w_mx[30]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_cnt   <= 4'd0;
                        r_acc   <= 64'd0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    // square into a product register, fold into the sum the next
                    if (r_cnt < 4'd3)
                        r_prod <= r_m[r_cnt[1:0]][30:0] * r_m[r_cnt[1:0]][30:0];
                    if (r_cnt != 4'd0)
                        r_acc <= r_acc + 64'(r_prod);
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        r_res   <= 64'd0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= N_ROOT;
                    end
                end
                N_ROOT: begin
                    if (r_bit == 64'd0) begin
                        r_k     <= 2'd0;
                        r_state <= N_DINIT;
                    end else begin
                        if (r_acc >= w_trial) begin
                            r_acc <= r_acc - w_trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                N_DINIT: begin
                    // numerator carries the rounding term len/2
                    r_rem   <= {1'b0, r_m[r_k][30:0], 14'd0} + 46'(r_res[31:1]);
                    r_den   <= {r_res[31:0], 14'd0};
                    r_q     <= '0;
                    r_cnt   <= 4'd0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (w_ge) r_rem <= r_rem - r_den;
                    r_den <= r_den >> 1;
                    r_q   <= w_qf[13:0];
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd14) begin
                        r_norm[r_k] <= r_neg[r_k] ? (16'd0 - {1'b0, w_qf}) : {1'b0, w_qf};
                        if (r_k == 2'd2) begin
                            r_state <= N_END;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= N_DINIT;
                        end
                    end
                end
                N_END: begin
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_norm = r_norm;

endmodule

// ===== rtl/core/vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted per-vertex normals with saturating accumulators and a
// normalizing query path.
// ----------------------------------------------------------------------------
// channel  | dir | handshake   | payload
// i_in     | in  | valid/ready | action, vertex_index, pos_x/y/z, corner_a/b/c
// o_out    | out | valid/ready | queried_index, normal_x/y/z
//
// Load: written straight from the accepted request. Triangle: three position
// reads, six products on one 17x17 multiplier, three read-modify-write
// accumulator updates. Query: set by the normalizer's range shift (up to 30
// steps), square root and three divisions; a zero sum ends at the shift.
// i_in.ready is high only while idle; a result blocked by a full output
// register reruns the normalizer until the register frees. No clearing pass.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vna_in_if.sink    i_in,
    vna_out_if.source o_out
);

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_TRA    = 11'b00000000010,
        S_TRB    = 11'b00000000100,
        S_TRC    = 11'b00000001000,
        S_EDGE   = 11'b00000010000,
        S_MUL    = 11'b00000100000,
        S_ARD    = 11'b00001000000,
        S_AWR    = 11'b00010000000,
        S_QRD    = 11'b00100000000,
        S_QSTART = 11'b01000000000,
        S_QWAIT  = 11'b10000000000
    } t_state;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < VERTEX_COUNT;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic signed [CROSS_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = 49'(signed'(a)) + 49'(b);
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return s[SUM_W-1:0];
    endfunction

    t_pos3 mem_pos [VERTEX_COUNT];
    t_sum3 mem_sum [VERTEX_COUNT];

    t_state                     r_state;
    t_pos3                      r_pos_q, r_pa, r_pb;
    t_sum3                      r_sum_q;
    logic [2:0][IDX_W-1:0]      r_corner;
    logic [IDX_W-1:0]           r_vi;
    logic                       r_qok;
    logic [1:0]                 r_k;
    logic [2:0]                 r_cnt;
    logic signed [EDGE_W-1:0]   r_e1 [3];
    logic signed [EDGE_W-1:0]   r_e2 [3];
    logic signed [2*EDGE_W-1:0] r_prod;
    logic signed [CROSS_W-1:0]  r_n [3];
    logic                       r_out_valid;
    logic [IDX_W-1:0]           r_out_idx;
    t_nrm3                      r_out_nrm;

    logic                       w_accept;
    logic                       w_tri_ok;
    logic [IDX_W-1:0]           w_rd_idx;
    logic signed [EDGE_W-1:0]   w_opa, w_opb;
    logic [2:0]                 w_fold;
    logic                       w_norm_start;
    logic                       w_norm_done;
    logic                       w_out_load;
    t_nrm3                      w_norm;
    t_sum3                      w_norm_in;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_tri_ok = idx_ok(i_in.corner_a) && idx_ok(i_in.corner_b)
                      && idx_ok(i_in.corner_c);
    assign w_fold   = r_cnt - 3'd1;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_QWAIT) && w_norm_done
                        && (!r_out_valid || o_out.ready);

    always_comb begin
        priority case (1'b1)
            r_state[1]: w_rd_idx = r_corner[0];
            r_state[2]: w_rd_idx = r_corner[1];
            r_state[3]: w_rd_idx = r_corner[2];
            r_state[6]: w_rd_idx = r_corner[r_k];
            default:    w_rd_idx = r_vi;
        endcase
    end

    // cross product operand order: n.x = y1*z2 - z1*y2, and so on
    always_comb begin
        unique case (r_cnt)
            3'd0:    begin w_opa = r_e1[1]; w_opb = r_e2[2]; end
            3'd1:    begin w_opa = r_e1[2]; w_opb = r_e2[1]; end
            3'd2:    begin w_opa = r_e1[2]; w_opb = r_e2[0]; end
            3'd3:    begin w_opa = r_e1[0]; w_opb = r_e2[2]; end
            3'd4:    begin w_opa = r_e1[0]; w_opb = r_e2[1]; end
            3'd5:    begin w_opa = r_e1[1]; w_opb = r_e2[0]; end
            default: begin w_opa = '0;      w_opb = '0;      end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.action == ACT_LOAD && idx_ok(i_in.vertex_index)) begin
            mem_pos[AW'(i_in.vertex_index)] <= {i_in.pos_z, i_in.pos_y, i_in.pos_x};
            mem_sum[AW'(i_in.vertex_index)] <= '0;
        end else if (r_state == S_AWR) begin
            for (int i = 0; i < 3; i++)
                mem_sum[AW'(r_corner[r_k])][i] <= sat_add(r_sum_q[i], r_n[i]);
        end
        r_pos_q <= mem_pos[AW'(w_rd_idx)];
        r_sum_q <= mem_sum[AW'(w_rd_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load)       r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_corner <= {i_in.corner_c, i_in.corner_b, i_in.corner_a};
                        r_vi     <= i_in.vertex_index;
                        r_qok    <= idx_ok(i_in.vertex_index);
                        if (i_in.action == ACT_TRI && w_tri_ok) r_state <= S_TRA;
                        else if (i_in.action == ACT_QUERY)      r_state <= S_QRD;
                    end
                end
                S_TRA: r_state <= S_TRB;
                S_TRB: begin
                    r_pa    <= r_pos_q;
                    r_state <= S_TRC;
                end
                S_TRC: begin
                    r_pb    <= r_pos_q;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= {r_pb[i][15], r_pb[i]} - {r_pa[i][15], r_pa[i]};
                        r_e2[i] <= {r_pos_q[i][15], r_pos_q[i]} - {r_pa[i][15], r_pa[i]};
                    end
                    r_cnt   <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= w_opa * w_opb;
                    if (r_cnt != 3'd0) begin
                        if (!w_fold[0]) r_n[w_fold[2:1]] <= CROSS_W'(r_prod);
                        else r_n[w_fold[2:1]] <= r_n[w_fold[2:1]] - CROSS_W'(r_prod);
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) begin
                        r_k     <= 2'd0;
                        r_state <= S_ARD;
                    end
                end
                S_ARD: r_state <= S_AWR;
                S_AWR: begin
                    if (r_k == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_ARD;
                    end
                end
                S_QRD:    r_state <= S_QSTART;
                S_QSTART: r_state <= S_QWAIT;
                S_QWAIT: begin
                    if (w_out_load) begin
                        r_out_idx   <= r_vi;
                        r_out_nrm   <= w_norm;
                        r_state     <= S_IDLE;
                    end else if (w_norm_done) begin
                        r_state     <= S_QSTART;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a blocked result is recomputed from the same read; the read data holds
    assign w_norm_start = (r_state == S_QSTART);
    assign w_norm_in    = r_qok ? r_sum_q : '0;

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_norm_start),
        .i_sum   (w_norm_in),
        .o_done  (w_norm_done),
        .o_norm  (w_norm)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.queried_index = r_out_idx;
    assign o_out.normal_x      = r_out_nrm[0];
    assign o_out.normal_y      = r_out_nrm[1];
    assign o_out.normal_z      = r_out_nrm[2];

    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_QWAIT && w_norm_done))
        else $error("result raised outside query completion");

    a_tri_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.action == ACT_TRI && w_tri_ok) |=> (r_state == S_TRA))
        else $error("triangle request not started");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_QWAIT) |-> !i_in.ready)
        else $error("request taken while busy");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vertex_normal_accumulator: loads, triangles and
// queries are predicted in the bench and every returned normal is compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import vna_pkg::*;

    localparam longint SUM_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam int     BIG_TRIS  = 300;
    localparam int     DRAIN_CYC = 300;

    typedef struct {
        t_action           act;
        logic [7:0]        vidx;
        logic signed [15:0] px, py, pz;
        logic [7:0]        ca, cb, cc;
    } t_request;

    typedef struct {
        logic [7:0]         idx;
        logic signed [15:0] nx, ny, nz;
    } t_normal;

    logic i_clk;
    logic i_rst_n;

    vna_in_if  in_ch();
    vna_out_if out_ch();

    vertex_normal_accumulator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // bench copy of the mesh state
    longint  vert_pos [256][3];
    longint  nrm_sum  [256][3];
    bit      is_loaded [256];
    int      loaded_list [$];
    t_normal pending_normals [$];

    int  n_errors;
    int  n_requests;
    int  n_normals;
    int  n_triangles;
    int  hold_left;
    bit  gaps_on;
    bit  stall_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("timeout at %0t", $time);
        $display("** vertex_normal_accumulator: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_HI) return SUM_HI;
        if (s < SUM_LO) return SUM_LO;
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_normal unit_normal(logic [7:0] idx);
        t_normal         r;
        longint unsigned m [3];
        longint unsigned mx, len, q;
        longint signed   o [3];
        r.idx = idx;
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = (nrm_sum[idx][k] < 0) ? -nrm_sum[idx][k] : nrm_sum[idx][k];
            if (m[k] > mx) mx = m[k];
        end
        if (mx == 0) begin
            r.nx = '0; r.ny = '0; r.nz = ONE_Q14;
            return r;
        end
        // bring the largest magnitude into [2^30, 2^31)
        while (mx >= (64'd1 << 31)) begin
            for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
            mx = mx << 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int k = 0; k < 3; k++) begin
            q    = ((m[k] << 14) + (len >> 1)) / len;
            o[k] = (nrm_sum[idx][k] < 0) ? -longint'(q) : longint'(q);
        end
        r.nx = o[0][15:0]; r.ny = o[1][15:0]; r.nz = o[2][15:0];
        return r;
    endfunction

    function automatic void mesh_apply(t_request r);
        longint e1 [3], e2 [3], n [3];
        int     ix [3];
        case (r.act)
            ACT_LOAD: begin
                vert_pos[r.vidx][0] = longint'(r.px);
                vert_pos[r.vidx][1] = longint'(r.py);
                vert_pos[r.vidx][2] = longint'(r.pz);
                for (int k = 0; k < 3; k++) nrm_sum[r.vidx][k] = 0;
                if (!is_loaded[r.vidx]) loaded_list.push_back(int'(r.vidx));
                is_loaded[r.vidx] = 1'b1;
            end
            ACT_TRI: begin
                ix[0] = int'(r.ca); ix[1] = int'(r.cb); ix[2] = int'(r.cc);
                for (int k = 0; k < 3; k++) begin
                    e1[k] = vert_pos[ix[1]][k] - vert_pos[ix[0]][k];
                    e2[k] = vert_pos[ix[2]][k] - vert_pos[ix[0]][k];
                end
                n[0] = e1[1] * e2[2] - e1[2] * e2[1];
                n[1] = e1[2] * e2[0] - e1[0] * e2[2];
                n[2] = e1[0] * e2[1] - e1[1] * e2[0];
                for (int s = 0; s < 3; s++)
                    for (int k = 0; k < 3; k++)
                        nrm_sum[ix[s]][k] = sat_sum(nrm_sum[ix[s]][k], n[k]);
                n_triangles++;
            end
            ACT_QUERY: pending_normals.push_back(unit_normal(r.vidx));
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- driving
    function automatic int gap_len();
        int p;
        if (!gaps_on) return 0;
        p = int'($urandom_range(99));
        if (p < 55) return 0;
        if (p < 92) return int'($urandom_range(3, 1));
        return int'($urandom_range(60, 10));
    endfunction

    task automatic send_request(t_request r);
        int gap;
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.action       <= r.act;
        in_ch.vertex_index <= r.vidx;
        in_ch.pos_x        <= r.px;
        in_ch.pos_y        <= r.py;
        in_ch.pos_z        <= r.pz;
        in_ch.corner_a     <= r.ca;
        in_ch.corner_b     <= r.cb;
        in_ch.corner_c     <= r.cc;
        do @(posedge i_clk); while (!in_ch.ready);
        mesh_apply(r);
        n_requests++;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_request rand_request(t_action act);
        t_request r;
        r.act  = act;
        r.vidx = 8'($urandom);
        r.px   = 16'($urandom); r.py = 16'($urandom); r.pz = 16'($urandom);
        r.ca   = 8'($urandom); r.cb = 8'($urandom); r.cc = 8'($urandom);
        return r;
    endfunction

    task automatic load_vertex(logic [7:0] idx, int x, int y, int z);
        t_request r;
        r = rand_request(ACT_LOAD);
        r.vidx = idx; r.px = 16'(x); r.py = 16'(y); r.pz = 16'(z);
        send_request(r);
    endtask

    task automatic add_triangle(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        t_request r;
        r = rand_request(ACT_TRI);
        r.ca = a; r.cb = b; r.cc = c;
        send_request(r);
    endtask

    task automatic query_vertex(logic [7:0] idx);
        t_request r;
        r = rand_request(ACT_QUERY);
        r.vidx = idx;
        send_request(r);
    endtask

    function automatic logic [7:0] any_loaded();
        return 8'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // result side: random stalls, plus a counted hold-off when requested
    initial begin
        int run;
        bit rdy;
        out_ch.ready = 1'b0;
        run = 0;
        rdy = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (run == 0) begin
                    if (!stall_on || $urandom_range(99) < 60) begin
                        rdy = 1'b1;
                        run = int'($urandom_range(40, 1));
                    end else begin
                        rdy = 1'b0;
                        run = ($urandom_range(9) == 0) ? int'($urandom_range(300, 50))
                                                       : int'($urandom_range(5, 1));
                    end
                end
                run--;
                out_ch.ready <= rdy;
            end
        end
    end

    // ---------------------------------------------------------------- checking
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected normal for vertex %0d", $time,
                         out_ch.queried_index);
                n_errors++;
            end else begin
                e = pending_normals.pop_front();
                n_normals++;
                if (out_ch.queried_index !== e.idx || out_ch.normal_x !== e.nx ||
                    out_ch.normal_y !== e.ny || out_ch.normal_z !== e.nz) begin
                    $display("%0t: normal mismatch: expected %0d (%0d %0d %0d) got %0d (%0d %0d %0d)",
                             $time, e.idx, e.nx, e.ny, e.nz, out_ch.queried_index,
                             out_ch.normal_x, out_ch.normal_y, out_ch.normal_z);
                    n_errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        t_request r;
        load_vertex(8'd0, -32768, -32768, -32768);
        load_vertex(8'd255, 32767, 32767, 32767);
        load_vertex(8'd1, 256, 0, 0);
        load_vertex(8'd2, 0, 256, 0);
        load_vertex(8'd3, 0, 0, 256);
        query_vertex(8'd3);                 // nothing accumulated: +z
        add_triangle(8'd3, 8'd1, 8'd2);
        query_vertex(8'd1);
        add_triangle(8'd0, 8'd255, 8'd1);
        query_vertex(8'd255);
        add_triangle(8'd2, 8'd2, 8'd1);     // repeated corner, zero area
        query_vertex(8'd2);
        add_triangle(8'd1, 8'd3, 8'd2);     // reverse winding cancels
        query_vertex(8'd3);
        r = rand_request(ACT_NONE);
        send_request(r);
        load_vertex(8'd1, 100, -200, 300);  // reload clears the sum
        query_vertex(8'd1);
        query_vertex(8'd0);
        wait_idle();
    endtask

    task automatic test_large_sums();
        bit g;
        g = gaps_on;
        gaps_on = 1'b0;
        // n = (+65535^2, 0, -65535^2): x grows large positive, z large negative
        load_vertex(8'd10, -32768, -32768, -32768);
        load_vertex(8'd11, -32768, 32767, -32768);
        load_vertex(8'd12, 32767, -32768, 32767);
        for (int i = 0; i < BIG_TRIS; i++) add_triangle(8'd10, 8'd11, 8'd12);
        query_vertex(8'd10);
        query_vertex(8'd12);
        add_triangle(8'd10, 8'd12, 8'd11);  // one step back the other way
        query_vertex(8'd11);
        gaps_on = g;
        wait_idle();
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        hold_left = 2500;
        for (int i = 0; i < 12; i++) query_vertex(any_loaded());
        wait_idle();
    endtask

    task automatic test_random(int count);
        t_request r;
        int       p;
        int       done;
        int       span;
        done = 0;
        while (done < count) begin
            p = int'($urandom_range(99));
            if (p < 10 || loaded_list.size() < 3) begin
                r = rand_request(ACT_LOAD);
                // small meshes give well-spread normals, full range hits extremes
                if ($urandom_range(3) != 0) begin
                    span = $urandom_range(3) == 0 ? 32767 : 2048;
                    r.px = 16'($urandom_range(2 * span) - span);
                    r.py = 16'($urandom_range(2 * span) - span);
                    r.pz = 16'($urandom_range(2 * span) - span);
                end
            end else if (p < 62) begin
                r = rand_request(ACT_TRI);
                r.ca = any_loaded(); r.cb = any_loaded(); r.cc = any_loaded();
            end else if (p < 97) begin
                r = rand_request(ACT_QUERY);
                r.vidx = any_loaded();
            end else begin
                r = rand_request(ACT_NONE);
            end
            send_request(r);
            if (r.act != ACT_NONE) done++;
            // alternate busy and quiet stretches on both sides
            if (done % 200 == 0) begin
                gaps_on  = $urandom_range(2) != 0;
                stall_on = $urandom_range(2) != 0;
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_NONE;
        in_ch.vertex_index = '0;
        in_ch.pos_x        = '0;
        in_ch.pos_y        = '0;
        in_ch.pos_z        = '0;
        in_ch.corner_a     = '0;
        in_ch.corner_b     = '0;
        in_ch.corner_c     = '0;
        n_errors    = 0;
        n_requests  = 0;
        n_normals   = 0;
        n_triangles = 0;
        hold_left   = 0;
        gaps_on     = 1'b1;
        stall_on    = 1'b1;
        for (int i = 0; i < 256; i++) begin
            is_loaded[i] = 1'b0;
            for (int k = 0; k < 3; k++) begin
                vert_pos[i][k] = 0;
                nrm_sum[i][k]  = 0;
            end
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_large_sums();
        test_backpressure();
        test_random(1400);

        $display("requests accepted: %0d, triangles: %0d, normals checked: %0d",
                 n_requests, n_triangles, n_normals);
        $display("covered extreme positions, large sums of both signs, stalls, %0d vertices",
                 loaded_list.size());
        if (n_errors == 0 && pending_normals.size() == 0) begin
            $display("** vertex_normal_accumulator: PASSED **");
        end else begin
            $display("errors: %0d, normals still owed: %0d", n_errors,
                     pending_normals.size());
            $display("** vertex_normal_accumulator: FAILED **");
        end
        $finish;
    end

endmodule
